// ===== hw/rtl/eul_pkg.sv =====
// eul_pkg: shared types, constants and fixed-point helpers for the
// euler angle to rotation matrix block; depends on nothing
package eul_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int ENTRY_BITS = 16;
    localparam int ENTRY_SH   = 31 - ENTRY_BITS;

    localparam logic [1:0] CONV_ZXZ  = 2'd0;
    localparam logic [1:0] CONV_XYZ  = 2'd1;
    localparam logic [1:0] CONV_ZYZ  = 2'd2;
    localparam logic [1:0] CONV_NONE = 2'd3;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    localparam int SIN_TERMS = 6;
    localparam int COS_TERMS = 7;

    localparam logic [30:0] SIN_C [0:SIN_TERMS-1] = '{
        31'd1686629713, 31'd693598669, 31'd85569306, 31'd5026995, 31'd172272, 31'd3864};
    localparam logic [30:0] COS_C [0:COS_TERMS-1] = '{
        31'd1073741824, 31'd1324675879, 31'd272375560, 31'd22401992, 31'd987048,
        31'd27060, 31'd506};

    typedef struct packed {
        logic [ANGLE_BITS-1:0] angle_psi;
        logic [ANGLE_BITS-1:0] angle_theta;
        logic [ANGLE_BITS-1:0] angle_phi;
    } t_angles;

    typedef struct packed {
        logic signed [ENTRY_BITS-1:0] r00;
        logic signed [ENTRY_BITS-1:0] r01;
        logic signed [ENTRY_BITS-1:0] r02;
        logic signed [ENTRY_BITS-1:0] r10;
        logic signed [ENTRY_BITS-1:0] r11;
        logic signed [ENTRY_BITS-1:0] r12;
        logic signed [ENTRY_BITS-1:0] r20;
        logic signed [ENTRY_BITS-1:0] r21;
        logic signed [ENTRY_BITS-1:0] r22;
    } t_matrix;

    // one horner step: c - floor(p*z / 2^30), floored at zero
    function automatic logic [30:0] horner_step(logic [30:0] c, logic [30:0] p,
                                                logic [29:0] z);
        logic [60:0] prod;
        logic [31:0] diff;
        prod = 61'(p) * 61'(z);
        diff = {1'b0, c} - {1'b0, prod[60:30]};
        return diff[31] ? 31'd0 : diff[30:0];
    endfunction

    // q30 product, magnitude rounded half away from zero
    function automatic logic signed [31:0] mq(logic signed [31:0] a, logic signed [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [61:0] pr;
        logic [31:0] r;
        ma = a[31] ? 32'(-a) : 32'(a);
        mb = b[31] ? 32'(-b) : 32'(b);
        pr = 62'(ma[30:0]) * 62'(mb[30:0]) + 62'(1) * (62'd1 << 29);
        r  = pr[61:30];
        return (a[31] ^ b[31]) ? -$signed(r) : $signed(r);
    endfunction

    // q30 sum to saturated signed entry
    function automatic logic [ENTRY_BITS-1:0] to_entry(logic signed [32:0] v);
        logic [32:0] m;
        logic [32:0] mr;
        logic [32:0] lim;
        m   = v[32] ? 33'(-v) : 33'(v);
        mr  = (m + (33'd1 << (ENTRY_SH - 1))) >> ENTRY_SH;
        lim = 33'd1 << (ENTRY_BITS - 1);
        if (v[32]) begin
            if (mr > lim) mr = lim;
            return ENTRY_BITS'(-mr);
        end
        if (mr > lim - 33'd1) mr = lim - 33'd1;
        return ENTRY_BITS'(mr);
    endfunction

endpackage

// ===== hw/rtl/eul_sincos.sv =====
// eul_sincos: pipelined sine and cosine of one binary angle, q30 results
// depends on eul_pkg; stage advance comes from the enclosing pipeline
module eul_sincos (
    input  logic                          i_clk,
    input  logic [7:0]                    i_en,
    input  logic [eul_pkg::ANGLE_BITS-1:0] i_angle,
    output logic signed [31:0]            o_sin,
    output logic signed [31:0]            o_cos
);
    import eul_pkg::*;

    localparam int NSTEP = COS_TERMS - 1;

    logic [1:0]  r_q  [0:NSTEP];
    logic [29:0] r_x  [0:NSTEP];
    logic [29:0] r_z  [0:NSTEP];
    logic [30:0] r_ps [1:NSTEP];
    logic [30:0] r_pc [1:NSTEP];
    logic signed [31:0] r_sin;
    logic signed [31:0] r_cos;

    logic [29:0] w_x;
    logic [59:0] w_xx;

    assign w_x  = {i_angle[ANGLE_BITS-3:0], (32 - ANGLE_BITS)'(0)};
    assign w_xx = 60'(w_x) * 60'(w_x);

    // quadrant split and z = x^2
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_q[0] <= i_angle[ANGLE_BITS-1 -: 2];
            r_x[0] <= w_x;
            r_z[0] <= w_xx[59:30];
        end
    end

    // horner steps: cosine in every stage, sine in all but the last
    for (genvar j = 0; j < NSTEP; j++) begin : g_step
        logic [30:0] w_ps_in;
        logic [30:0] w_pc_in;
        if (j == 0) begin : g_first
            assign w_ps_in = SIN_C[SIN_TERMS-1];
            assign w_pc_in = COS_C[COS_TERMS-1];
        end else begin : g_rest
            assign w_ps_in = r_ps[j];
            assign w_pc_in = r_pc[j];
        end
        always_ff @(posedge i_clk) begin
            if (i_en[j+1]) begin
                r_q[j+1] <= r_q[j];
                r_x[j+1] <= r_x[j];
                r_z[j+1] <= r_z[j];
                r_pc[j+1] <= horner_step(COS_C[NSTEP-1-j], w_pc_in, r_z[j]);
                if (j < SIN_TERMS - 1) begin
                    r_ps[j+1] <= horner_step(
                        SIN_C[(j < SIN_TERMS - 1) ? SIN_TERMS-2-j : 0], w_ps_in, r_z[j]);
                end else begin
                    r_ps[j+1] <= w_ps_in;
                end
            end
        end
    end

    logic [60:0] w_sx;
    logic [31:0] w_s;
    logic [31:0] w_c;

    always_comb begin
        w_sx = 61'(r_ps[NSTEP]) * 61'(r_x[NSTEP]);
        w_s  = (w_sx[60:30] > Q30_ONE) ? 32'(Q30_ONE) : 32'(w_sx[60:30]);
        w_c  = (r_pc[NSTEP] > Q30_ONE) ? 32'(Q30_ONE) : 32'(r_pc[NSTEP]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            case (r_q[NSTEP])
                2'd0: begin
                    r_sin <= $signed(w_s);
                    r_cos <= $signed(w_c);
                end
                2'd1: begin
                    r_sin <= $signed(w_c);
                    r_cos <= -$signed(w_s);
                end
                2'd2: begin
                    r_sin <= -$signed(w_s);
                    r_cos <= -$signed(w_c);
                end
                default: begin
                    r_sin <= -$signed(w_c);
                    r_cos <= $signed(w_s);
                end
            endcase
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ===== hw/rtl/euler_angles_to_rotation_matrix.sv =====
// euler_angles_to_rotation_matrix: top level, angle request to 3x3 matrix
// depends on eul_pkg and eul_sincos
//
// usage:
//   input channel: i_valid / o_stall with an eul_pkg::t_angles request,
//   taken at a clock edge with i_valid high and o_stall low
//   output channel: o_valid / i_stall with an eul_pkg::t_matrix result,
//   taken at a clock edge with o_valid high and i_stall low
//   config: apb-style write of convention at byte address 0
//   (0 zxz, 1 xyz, 2 zyz, 3 gives an all-zero matrix); pready is tied high
// pipeline: 8 stages of sine/cosine (quadrant, six horner steps, final
//   scale), then first products, second products, sum and saturation
// throughput: one request per cycle while the output is not stalled
// stall: each stage has its own valid bit and loads when it is empty or
//   the stage after it moves, so bubbles close up and a stalled result
//   holds in the output register while earlier stages keep filling
// reset: clears all valid bits and sets convention to zxz
module euler_angles_to_rotation_matrix (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  eul_pkg::t_angles i_req,
    output logic             o_valid,
    input  logic             i_stall,
    output eul_pkg::t_matrix o_rsp,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import eul_pkg::*;

    localparam int NST = 11;

    // config register
    logic [1:0] r_conv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conv <= CONV_ZXZ;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_conv <= pwdata[1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {30'd0, r_conv} : 32'd0;

    // per-stage valid and advance chain
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;
    logic [NST-1:0] w_vld_in;

    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || !i_stall;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    // valid bit that each stage takes when it advances
    assign w_vld_in = {r_vld[NST-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= w_vld_in[k];
                end
            end
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[NST-1];

    // sine and cosine of the three angles
    logic signed [31:0] w_sps, w_cps, w_sth, w_cth, w_sph, w_cph;

    eul_sincos u_psi (
        .i_clk   (i_clk),
        .i_en    (w_en[7:0]),
        .i_angle (i_req.angle_psi),
        .o_sin   (w_sps),
        .o_cos   (w_cps)
    );

    eul_sincos u_theta (
        .i_clk   (i_clk),
        .i_en    (w_en[7:0]),
        .i_angle (i_req.angle_theta),
        .o_sin   (w_sth),
        .o_cos   (w_cth)
    );

    eul_sincos u_phi (
        .i_clk   (i_clk),
        .i_en    (w_en[7:0]),
        .i_angle (i_req.angle_phi),
        .o_sin   (w_sph),
        .o_cos   (w_cph)
    );

    // every entry is s1*mq(a,b) + s2*mq(mq(c,d),e); single terms use c = 0
    // and a bare sine or cosine uses b = one
    logic signed [31:0] w_a [0:8];
    logic signed [31:0] w_b [0:8];
    logic signed [31:0] w_c [0:8];
    logic signed [31:0] w_d [0:8];
    logic signed [31:0] w_e [0:8];
    logic [8:0]         w_n1;
    logic [8:0]         w_n2;
    logic signed [31:0] w_one;

    assign w_one = $signed(32'(Q30_ONE));

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_a[k] = '0;
            w_b[k] = '0;
            w_c[k] = '0;
            w_d[k] = '0;
            w_e[k] = '0;
        end
        w_n1 = '0;
        w_n2 = '0;
        unique case (r_conv)
            CONV_ZXZ: begin
                w_a[0] = w_cps; w_b[0] = w_cph;
                w_c[0] = w_cth; w_d[0] = w_sph; w_e[0] = w_sps; w_n2[0] = 1'b1;
                w_a[1] = w_cps; w_b[1] = w_sph;
                w_c[1] = w_cth; w_d[1] = w_cph; w_e[1] = w_sps;
                w_a[2] = w_sps; w_b[2] = w_sth;
                w_a[3] = w_sps; w_b[3] = w_cph; w_n1[3] = 1'b1;
                w_c[3] = w_cth; w_d[3] = w_sph; w_e[3] = w_cps; w_n2[3] = 1'b1;
                w_a[4] = w_sps; w_b[4] = w_sph; w_n1[4] = 1'b1;
                w_c[4] = w_cth; w_d[4] = w_cph; w_e[4] = w_cps;
                w_a[5] = w_cps; w_b[5] = w_sth;
                w_a[6] = w_sth; w_b[6] = w_sph;
                w_a[7] = w_sth; w_b[7] = w_cph; w_n1[7] = 1'b1;
                w_a[8] = w_cth; w_b[8] = w_one;
            end
            CONV_XYZ: begin
                w_a[0] = w_cth; w_b[0] = w_cph;
                w_a[1] = w_cth; w_b[1] = w_sph;
                w_a[2] = w_sth; w_b[2] = w_one; w_n1[2] = 1'b1;
                w_c[3] = w_sps; w_d[3] = w_sth; w_e[3] = w_cph;
                w_a[3] = w_cps; w_b[3] = w_sph; w_n1[3] = 1'b1;
                w_c[4] = w_sps; w_d[4] = w_sth; w_e[4] = w_sph;
                w_a[4] = w_cph; w_b[4] = w_cps;
                w_a[5] = w_cth; w_b[5] = w_sps;
                w_c[6] = w_cps; w_d[6] = w_sth; w_e[6] = w_cph;
                w_a[6] = w_sps; w_b[6] = w_sph;
                w_c[7] = w_cps; w_d[7] = w_sth; w_e[7] = w_sph;
                w_a[7] = w_sps; w_b[7] = w_cph; w_n1[7] = 1'b1;
                w_a[8] = w_cth; w_b[8] = w_cps;
            end
            CONV_ZYZ: begin
                w_a[0] = w_sps; w_b[0] = w_sph; w_n1[0] = 1'b1;
                w_c[0] = w_cth; w_d[0] = w_cph; w_e[0] = w_cps;
                w_a[1] = w_sps; w_b[1] = w_cph;
                w_c[1] = w_cth; w_d[1] = w_sph; w_e[1] = w_cps;
                w_a[2] = w_cps; w_b[2] = w_sth; w_n1[2] = 1'b1;
                w_a[3] = w_cps; w_b[3] = w_sph; w_n1[3] = 1'b1;
                w_c[3] = w_cth; w_d[3] = w_cph; w_e[3] = w_sps; w_n2[3] = 1'b1;
                w_a[4] = w_cps; w_b[4] = w_cph;
                w_c[4] = w_cth; w_d[4] = w_sph; w_e[4] = w_sps; w_n2[4] = 1'b1;
                w_a[5] = w_sps; w_b[5] = w_sth;
                w_a[6] = w_sth; w_b[6] = w_cph;
                w_a[7] = w_sth; w_b[7] = w_sph;
                w_a[8] = w_cth; w_b[8] = w_one;
            end
            default: begin
                // undefined convention: all products stay zero
            end
        endcase
    end

    // first products
    logic signed [31:0] r_p1a [0:8];
    logic signed [31:0] r_p2a [0:8];
    logic signed [31:0] r_ea  [0:8];
    logic [8:0]         r_n1a;
    logic [8:0]         r_n2a;

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            for (int k = 0; k < 9; k++) begin
                r_p1a[k] <= mq(w_a[k], w_b[k]);
                r_p2a[k] <= mq(w_c[k], w_d[k]);
                r_ea[k]  <= w_e[k];
            end
            r_n1a <= w_n1;
            r_n2a <= w_n2;
        end
    end

    // second product of the three-factor terms
    logic signed [31:0] r_p1b [0:8];
    logic signed [31:0] r_p3b [0:8];
    logic [8:0]         r_n1b;
    logic [8:0]         r_n2b;

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            for (int k = 0; k < 9; k++) begin
                r_p1b[k] <= r_p1a[k];
                r_p3b[k] <= mq(r_p2a[k], r_ea[k]);
            end
            r_n1b <= r_n1a;
            r_n2b <= r_n2a;
        end
    end

    // signed sum, rounding and saturation into the output register
    logic [ENTRY_BITS-1:0] w_ent [0:8];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_ent[k] = to_entry(
                (r_n1b[k] ? -33'(r_p1b[k]) : 33'(r_p1b[k])) +
                (r_n2b[k] ? -33'(r_p3b[k]) : 33'(r_p3b[k])));
        end
    end

    t_matrix r_rsp;

    always_ff @(posedge i_clk) begin
        if (w_en[10]) begin
            r_rsp.r00 <= w_ent[0];
            r_rsp.r01 <= w_ent[1];
            r_rsp.r02 <= w_ent[2];
            r_rsp.r10 <= w_ent[3];
            r_rsp.r11 <= w_ent[4];
            r_rsp.r12 <= w_ent[5];
            r_rsp.r20 <= w_ent[6];
            r_rsp.r21 <= w_ent[7];
            r_rsp.r22 <= w_ent[8];
        end
    end

    assign o_rsp = r_rsp;

endmodule
